// ===== rtl/calendar_date_advance_core_assert.svh =====
// assertion macros for the calendar date advance core
`ifndef CALENDAR_DATE_ADVANCE_CORE_ASSERT_SVH
`define CALENDAR_DATE_ADVANCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define CDA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cda assertion failed");
// checked also while reset is applied
`define CDA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cda assertion failed");
`else
`define CDA_ASSERT(lbl, prop)
`define CDA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/cda_pkg.sv =====
// shared types and constants of the calendar date advance core
`default_nettype none

package cda_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned DAY_COUNT_W    = 16;
  localparam int unsigned IN_DATA_W      = 40;
  localparam int unsigned OUT_DATA_W     = 48;

  localparam logic [11:0] YEAR_MIN  = 12'd1900;
  localparam logic [11:0] YEAR_MAX  = 12'd2100;
  localparam logic [11:0] YEAR_TOP  = 12'd4095;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [4:0]  DAY_FIRST = 5'd1;
  localparam logic [4:0]  DAY_LAST  = 5'd31;

  localparam logic OP_SET     = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_MONTH = 2'd1,
    STAT_BAD_YEAR  = 2'd2,
    STAT_BAD_DAY   = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]  month;
    logic [4:0]  day;
    logic [11:0] year;
  } date_t;

  // result of the shared date unit
  typedef struct packed {
    logic [4:0] mlen;
    logic       day_lt;
    logic       day_le;
    date_t      nxt;
  } step_t;

endpackage

`default_nettype wire

// ===== rtl/calendar_date_advance_core.sv =====
// top level of the calendar date advance core: sequencer, date state, stream ports
`default_nettype none

// Gregorian date counter (month, day, year), reset to 1900-01-01. Each input
// beat gives exactly one output beat with the date before and after it. A set
// beat (tuser = 0) checks month 1..12, then year 1900..2100, then day against
// the requested month length (Feb 29 in leap years); status names the first
// failing field and the date is only written when all pass. An advance beat
// (tuser = 1) steps the date one day per clock through the shared date unit,
// using the low COUNT_BITS bits of day_count (all of it if COUNT_BITS > 16),
// and holds at 4095-12-31. A set passes through the check state and then the
// output load; an advance steps until the count runs out or the top date is
// reached and then loads the output. The core takes one beat at a time:
// s_axis_tready is high only while no item is in work, and a finished result
// waits for the output register to free up if the sink stalls.
module calendar_date_advance_core #(
  parameter int unsigned COUNT_BITS = cda_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [3:0] set_month, [9:4] set_day, [21:10] set_year, [37:22] day_count
  input  logic [cda_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] op
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [3:0] prev_month, [8:4] prev_day, [20:9] prev_year, [24:21] cur_month,
  // [29:25] cur_day, [41:30] cur_year, [43:42] status
  output logic [cda_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import cda_pkg::*;

  `include "calendar_date_advance_core_assert.svh"

  localparam int unsigned LoadW = (COUNT_BITS < DAY_COUNT_W) ? COUNT_BITS : DAY_COUNT_W;

  // sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SET  = 2'd1;
  localparam logic [1:0] ST_ADV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]            state_q, state_d;
  date_t                 date_q, date_d;
  date_t                 prev_q;
  status_e               status_q, status_d;
  logic [3:0]            set_month_q;
  logic [5:0]            set_day_q;
  logic [11:0]           set_year_q;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  m_tvalid_q;
  logic [OUT_DATA_W-1:0] m_tdata_q;

  // input beat fields
  logic [3:0]             in_month;
  logic [5:0]             in_day;
  logic [11:0]            in_year;
  logic [DAY_COUNT_W-1:0] in_count;
  logic [COUNT_BITS-1:0]  cnt_load;
  logic                   in_accept;
  logic                   out_free;

  // shared unit operands and result
  logic [3:0]  u_month;
  logic [5:0]  u_day;
  logic [11:0] u_year;
  step_t       step;
  logic        at_top;

  assign in_month  = s_axis_tdata[3:0];
  assign in_day    = s_axis_tdata[9:4];
  assign in_year   = s_axis_tdata[21:10];
  assign in_count  = s_axis_tdata[37:22];
  assign cnt_load  = COUNT_BITS'(in_count[LoadW-1:0]);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_tvalid_q || m_axis_tready;

  // set check uses the requested fields, advance uses the stored date
  assign u_month = (state_q == ST_SET) ? set_month_q : date_q.month;
  assign u_day   = (state_q == ST_SET) ? set_day_q   : {1'b0, date_q.day};
  assign u_year  = (state_q == ST_SET) ? set_year_q  : date_q.year;

  cda_date_unit u_date_unit (
    .month_i (u_month),
    .day_i   (u_day),
    .year_i  (u_year),
    .step_o  (step)
  );

  assign at_top = (date_q.year == YEAR_TOP) && (date_q.month == MONTH_DEC)
                  && (date_q.day >= DAY_LAST);

  always_comb begin
    state_d  = state_q;
    date_d   = date_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d  = (s_axis_tuser == OP_SET) ? ST_SET : ST_ADV;
          status_d = STAT_OK;
          cnt_d    = cnt_load;
        end
      end
      ST_SET: begin
        // first failing field wins: month, then year, then day
        priority if (set_month_q < MONTH_JAN || set_month_q > MONTH_DEC) begin
          status_d = STAT_BAD_MONTH;
        end else if (set_year_q < YEAR_MIN || set_year_q > YEAR_MAX) begin
          status_d = STAT_BAD_YEAR;
        end else if (set_day_q == 6'd0 || !step.day_le) begin
          status_d = STAT_BAD_DAY;
        end else begin
          status_d     = STAT_OK;
          date_d.month = set_month_q;
          date_d.day   = set_day_q[4:0];
          date_d.year  = set_year_q;
        end
        state_d = ST_DONE;
      end
      ST_ADV: begin
        // one day per cycle until the count runs out or the top date
        if ((cnt_q != '0) && !at_top) begin
          date_d = step.nxt;
          cnt_d  = cnt_q - COUNT_BITS'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state and the stored date
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      date_q     <= '{month: MONTH_JAN, day: DAY_FIRST, year: YEAR_MIN};
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      date_q  <= date_d;
      if (state_q == ST_DONE && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    status_q <= status_d;
    if (in_accept) begin
      prev_q      <= date_q;
      set_month_q <= in_month;
      set_day_q   <= in_day;
      set_year_q  <= in_year;
    end
    if (state_q == ST_DONE && out_free) begin
      m_tdata_q <= {4'b0, status_q, date_q.year, date_q.day, date_q.month,
                    prev_q.year, prev_q.day, prev_q.month};
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // stored month is always a real month
  `CDA_ASSERT(a_month_range, (date_q.month >= MONTH_JAN) && (date_q.month <= MONTH_DEC))
  // a rejected set leaves the date alone
  `CDA_ASSERT(a_reject_keeps, (state_q == ST_SET) && (status_d != STAT_OK) |=> $stable(date_q))
  // each advancing cycle takes exactly one off the count
  `CDA_ASSERT(a_cnt_step, (state_q == ST_ADV) && (cnt_q != '0) && !at_top |=> cnt_q == $past(cnt_q) - COUNT_BITS'(1))
  // the date never moves past the top
  `CDA_ASSERT(a_top_holds, (state_q == ST_ADV) && at_top |=> $stable(date_q))
  // no input taken while an item is in work
  `CDA_ASSERT_ALWAYS(a_ready_idle, s_axis_tready |-> (state_q == ST_IDLE))

endmodule

`default_nettype wire

// ===== rtl/cda_date_unit.sv =====
// shared date unit: month length, day compare and next-day increment
`default_nettype none

module cda_date_unit (
  input  logic [3:0]    month_i,
  input  logic [5:0]    day_i,
  input  logic [11:0]   year_i,
  output cda_pkg::step_t step_o
);
  import cda_pkg::*;

  // leap test without a divider: y/100 by reciprocal, exact for 12-bit years
  function automatic logic is_leap(input logic [11:0] yr);
    logic [24:0] prod;
    logic [5:0]  q;
    logic [11:0] c100;
    logic        div100;
    logic        div400;
    prod   = 25'(yr) * 25'd5243;
    q      = prod[24:19];
    c100   = {q, 6'b0} + {1'b0, q, 5'b0} + {4'b0, q, 2'b0};
    div100 = (c100 == yr);
    div400 = div100 && (q[1:0] == 2'b00);
    return div400 || (!div100 && (yr[1:0] == 2'b00));
  endfunction

  logic [4:0] mlen;
  logic       leap;

  assign leap = is_leap(year_i);

  always_comb begin
    unique case (month_i)
      4'd2:                                     mlen = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                  mlen = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: mlen = 5'd31;
      default:                                  mlen = 5'd0;
    endcase
  end

  always_comb begin
    step_o.mlen   = mlen;
    step_o.day_lt = day_i < {1'b0, mlen};
    step_o.day_le = day_i <= {1'b0, mlen};
    if (step_o.day_lt) begin
      step_o.nxt.month = month_i;
      step_o.nxt.day   = day_i[4:0] + 5'd1;
      step_o.nxt.year  = year_i;
    end else if (month_i < MONTH_DEC) begin
      step_o.nxt.month = month_i + 4'd1;
      step_o.nxt.day   = DAY_FIRST;
      step_o.nxt.year  = year_i;
    end else begin
      step_o.nxt.month = MONTH_JAN;
      step_o.nxt.day   = DAY_FIRST;
      step_o.nxt.year  = year_i + 12'd1;
    end
  end

endmodule

`default_nettype wire
